// ===== sv/line_follow_pid_steering_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Line follow PID steering unit assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOW_PID_STEERING_UNIT_MACROS_SVH
`define LINE_FOLLOW_PID_STEERING_UNIT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define LFPS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// A condition that, once seen, forces another condition in the next cycle.
`define LFPS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/lfps_pkg.sv =====
// ----------------------------------------------------------------------------
// Line follow PID steering package
// Types, register indexes and fixed constants shared by the steering unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfps_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;
    localparam int POS_W      = 7;
    localparam int ERR_W      = 8;
    localparam int DRIVE_W    = 18;
    localparam int COUNT_W    = 4;

    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 48;

    // Filter, integral and boost constants.
    localparam int NO_LINE          = -1;
    localparam int JUMP_LIMIT       = 16;
    localparam int DEADBAND         = 4;
    localparam int SUM_LIMIT        = 120;
    localparam int SUM_RELOAD       = 100;
    localparam int BOOST_LO         = 14;
    localparam int BOOST_HI         = 18;
    localparam int BOOST_COUNT_MAX  = 14;
    localparam int BOOST_ARM        = 4;

    localparam int TARGET_POS_RESET = 16;
    localparam int CRUISE_RESET     = 800;
    localparam int BOOST_RESET      = 1200;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TARGET_POS   = 3'd0,
        REG_GAIN_P       = 3'd1,
        REG_GAIN_I       = 3'd2,
        REG_GAIN_D       = 3'd3,
        REG_CRUISE_SPEED = 3'd4,
        REG_BOOST_SPEED  = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [5:0]  target_pos;
        logic [7:0]  gain_p;
        logic [7:0]  gain_i;
        logic [7:0]  gain_d;
        logic [11:0] cruise_speed;
        logic [11:0] boost_speed;
    } cfg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] prev_position;
        logic signed [ERR_W-1:0] prev_error;
        logic signed [ERR_W-1:0] error_sum;
        logic [COUNT_W-1:0]      boost_count;
    } state_t;

    typedef struct packed {
        logic signed [POS_W-1:0]   used_position;
        logic signed [DRIVE_W-1:0] right_drive;
        logic signed [DRIVE_W-1:0] left_drive;
    } result_t;

endpackage

// ===== sv/line_follow_pid_steering_unit.sv =====
// ----------------------------------------------------------------------------
// Line follow PID steering unit
// Filters line positions and turns them into left and right motor drives.
// ----------------------------------------------------------------------------
// Each input beat carries one measured line position and yields exactly one
// result beat with the left and right drive values and the filtered position.
// A beat is registered on entry, then combinational logic (filter, three gain
// multiplies, boost counter) updates the controller state and loads the
// result register, so a beat passes the input register and then the result
// register, and one beat can be taken every cycle while the output
// side keeps up. Configuration writes take effect at once and should be made
// while no beat is in flight.
`timescale 1ns / 1ps

module line_follow_pid_steering_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Fields from bit 0: position[6:0].
    input  logic [lfps_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: left_drive[17:0], right_drive[35:18], used_position[42:36].
    output logic [lfps_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_wr_en,
    input  logic [lfps_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [lfps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import lfps_pkg::*;

    cfg_t                    cfg_reg;
    state_t                  state_reg;
    state_t                  state_next;
    result_t                 result_next;
    result_t                 out_reg;
    logic                    out_vld_reg;
    logic                    in_vld_reg;
    logic signed [POS_W-1:0] in_pos_reg;
    logic                    advance;
    logic                    fire;

    assign advance  = !out_vld_reg || m_tready;
    assign fire     = in_vld_reg && advance;
    assign s_tready = !in_vld_reg || advance;

    lfps_pid_core u_core (
        .position   (in_pos_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_pos   <= 6'(TARGET_POS_RESET);
            cfg_reg.gain_p       <= '0;
            cfg_reg.gain_i       <= '0;
            cfg_reg.gain_d       <= '0;
            cfg_reg.cruise_speed <= 12'(CRUISE_RESET);
            cfg_reg.boost_speed  <= 12'(BOOST_RESET);
        end else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_addr))
                REG_TARGET_POS:   cfg_reg.target_pos   <= cfg_wdata[5:0];
                REG_GAIN_P:       cfg_reg.gain_p       <= cfg_wdata[7:0];
                REG_GAIN_I:       cfg_reg.gain_i       <= cfg_wdata[7:0];
                REG_GAIN_D:       cfg_reg.gain_d       <= cfg_wdata[7:0];
                REG_CRUISE_SPEED: cfg_reg.cruise_speed <= cfg_wdata;
                REG_BOOST_SPEED:  cfg_reg.boost_speed  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_vld_reg <= 1'b1;
            end else if (fire) begin
                in_vld_reg <= 1'b0;
            end
            if (fire) begin
                out_vld_reg <= 1'b1;
                state_reg   <= state_next;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_pos_reg <= s_tdata[POS_W-1:0];
        end
        if (fire) begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'd0, out_reg.used_position, out_reg.right_drive, out_reg.left_drive};

`include "line_follow_pid_steering_unit_macros.svh"

    `LFPS_ASSERT_ALWAYS(a_boost_count_range, state_reg.boost_count <= BOOST_COUNT_MAX, "boost count out of range")
    `LFPS_ASSERT_ALWAYS(a_error_sum_range, (state_reg.error_sum <= SUM_LIMIT) && (state_reg.error_sum >= -SUM_LIMIT), "integral out of range")
    `LFPS_ASSERT_ALWAYS(a_result_matches_state, !out_vld_reg || (out_reg.used_position == state_reg.prev_position), "result position differs from stored position")
    `LFPS_ASSERT_NEXT(a_accept_loads_input, s_tvalid && s_tready, in_vld_reg, "accepted beat not held in input stage")

endmodule

// ===== sv/lfps_pid_core.sv =====
// ----------------------------------------------------------------------------
// Line follow PID core
// Single pass datapath: position filter, PID terms, boost logic and drives.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfps_pid_core (
    input  logic signed [lfps_pkg::POS_W-1:0] position,
    input  lfps_pkg::cfg_t                    cfg,
    input  lfps_pkg::state_t                  state,
    output lfps_pkg::state_t                  state_next,
    output lfps_pkg::result_t                 result
);
    import lfps_pkg::*;

    logic signed [POS_W:0]   jump;
    logic                    reject;
    logic signed [POS_W-1:0] used;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W:0]   der;
    logic signed [ERR_W:0]   sum_raw;
    logic signed [ERR_W-1:0] sum;
    logic signed [16:0]      term_p;
    logic signed [17:0]      term_d;
    logic signed [16:0]      term_i;
    logic signed [18:0]      corr;
    logic signed [18:0]      base;
    logic signed [18:0]      left_full;
    logic signed [18:0]      right_full;
    logic                    in_window;
    logic [COUNT_W-1:0]      count_inc;
    logic [COUNT_W-1:0]      count_next;

    always_comb begin
        jump   = {position[POS_W-1], position} -
                 {state.prev_position[POS_W-1], state.prev_position};
        reject = (position == POS_W'(NO_LINE)) || (jump > JUMP_LIMIT) || (jump < -JUMP_LIMIT);
        used   = reject ? state.prev_position : position;

        err = $signed({2'b00, cfg.target_pos}) - $signed({used[POS_W-1], used});
        der = {err[ERR_W-1], err} - {state.prev_error[ERR_W-1], state.prev_error};

        // Inside the deadband the integral is dropped rather than held.
        if (err > DEADBAND || err < -DEADBAND) begin
            sum_raw = {state.error_sum[ERR_W-1], state.error_sum} + {err[ERR_W-1], err};
        end else begin
            sum_raw = '0;
        end
        if (sum_raw > SUM_LIMIT) begin
            sum = ERR_W'(SUM_RELOAD);
        end else if (sum_raw < -SUM_LIMIT) begin
            sum = ERR_W'(-SUM_RELOAD);
        end else begin
            sum = sum_raw[ERR_W-1:0];
        end

        term_p = err * $signed({1'b0, cfg.gain_p});
        term_d = der * $signed({1'b0, cfg.gain_d});
        term_i = sum * $signed({1'b0, cfg.gain_i});
        corr   = 19'(term_p) + 19'(term_d) + 19'(term_i);

        in_window = (used > BOOST_LO) && (used < BOOST_HI);
        count_inc = state.boost_count + 1'b1;
        if (in_window && state.boost_count < BOOST_COUNT_MAX) begin
            count_next = count_inc;
            base = (count_inc > BOOST_ARM) ? $signed({7'd0, cfg.boost_speed})
                                           : $signed({7'd0, cfg.cruise_speed});
        end else begin
            count_next = '0;
            base       = $signed({7'd0, cfg.cruise_speed});
        end

        left_full  = base - corr;
        right_full = base + corr;

        state_next.prev_position = used;
        state_next.prev_error    = err;
        state_next.error_sum     = sum;
        state_next.boost_count   = count_next;

        result.used_position = used;
        result.left_drive    = left_full[DRIVE_W-1:0];
        result.right_drive   = right_full[DRIVE_W-1:0];
    end

endmodule

// ===== dv/line_follow_pid_steering_checker.sv =====
// ----------------------------------------------------------------------------
// Line follow PID steering checker
// Watches the position, drive and register ports of the steering unit, keeps
// its own copy of the controller state and compares every drive beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_follow_pid_steering_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Fields from bit 0: position[6:0].
    input  logic [lfps_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    // Fields from bit 0: left_drive[17:0], right_drive[35:18], used_position[42:36].
    input  logic [lfps_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_wr_en,
    input  logic [lfps_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [lfps_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output int                                  mismatch_count,
    output int                                  outstanding,
    output int                                  drives_checked
);
    import lfps_pkg::*;

    cfg_t                     settings;
    logic signed [POS_W-1:0]  last_position;
    logic signed [ERR_W-1:0]  held_error;
    logic signed [ERR_W-1:0]  error_total;
    logic [COUNT_W-1:0]       window_count;
    result_t                  drive_q[$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] drive mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Advances the controller by one position and returns the drive beat it causes.
    function automatic result_t predict_drives(input logic signed [POS_W-1:0] raw);
        int      pos;
        int      jump;
        int      err;
        int      der;
        int      total;
        int      corr;
        int      base;
        int      left;
        int      right;
        result_t r;
        pos  = raw;
        jump = (pos > last_position) ? pos - last_position : last_position - pos;
        if (pos == NO_LINE || jump > JUMP_LIMIT) begin
            pos = last_position;
        end
        last_position = pos[POS_W-1:0];

        err = int'(settings.target_pos) - pos;
        der = err - held_error;
        if (err > DEADBAND || err < -DEADBAND) begin
            total = error_total + err;
        end else begin
            total = 0;
        end
        // The clamp reloads to a smaller magnitude instead of saturating.
        if (total > SUM_LIMIT) begin
            total = SUM_RELOAD;
        end
        if (total < -SUM_LIMIT) begin
            total = -SUM_RELOAD;
        end
        error_total = total[ERR_W-1:0];
        held_error  = err[ERR_W-1:0];

        corr = err * int'(settings.gain_p) + der * int'(settings.gain_d)
             + total * int'(settings.gain_i);

        if (pos > BOOST_LO && pos < BOOST_HI && window_count < BOOST_COUNT_MAX) begin
            window_count = window_count + 1'b1;
            base = (window_count > BOOST_ARM) ? int'(settings.boost_speed)
                                              : int'(settings.cruise_speed);
        end else begin
            window_count = '0;
            base = int'(settings.cruise_speed);
        end

        left  = base - corr;
        right = base + corr;
        r.left_drive    = left[DRIVE_W-1:0];
        r.right_drive   = right[DRIVE_W-1:0];
        r.used_position = pos[POS_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            settings.target_pos   = 6'(TARGET_POS_RESET);
            settings.gain_p       = '0;
            settings.gain_i       = '0;
            settings.gain_d       = '0;
            settings.cruise_speed = 12'(CRUISE_RESET);
            settings.boost_speed  = 12'(BOOST_RESET);
            last_position         = '0;
            held_error            = '0;
            error_total           = '0;
            window_count          = '0;
            drive_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_TARGET_POS:   settings.target_pos   = cfg_wdata[5:0];
                    REG_GAIN_P:       settings.gain_p       = cfg_wdata[7:0];
                    REG_GAIN_I:       settings.gain_i       = cfg_wdata[7:0];
                    REG_GAIN_D:       settings.gain_d       = cfg_wdata[7:0];
                    REG_CRUISE_SPEED: settings.cruise_speed = cfg_wdata[11:0];
                    REG_BOOST_SPEED:  settings.boost_speed  = cfg_wdata[11:0];
                    default: ;
                endcase
            end
            // A drive beat leaving now can never belong to a position entering now,
            // so the pop comes before the push.
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (drive_q.size() == 0) begin
                    report_mismatch($sformatf("drive beat %h with nothing expected", m_tdata));
                end else begin
                    want = drive_q.pop_front();
                    drives_checked++;
                    if (got.left_drive !== want.left_drive) begin
                        report_mismatch($sformatf("left_drive got %0d expected %0d",
                                                  got.left_drive, want.left_drive));
                    end
                    if (got.right_drive !== want.right_drive) begin
                        report_mismatch($sformatf("right_drive got %0d expected %0d",
                                                  got.right_drive, want.right_drive));
                    end
                    if (got.used_position !== want.used_position) begin
                        report_mismatch($sformatf("used_position got %0d expected %0d",
                                                  got.used_position, want.used_position));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                drive_q.push_back(predict_drives(s_tdata[POS_W-1:0]));
            end
        end
        outstanding <= drive_q.size();
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Line follow PID steering unit testbench
// Drives line positions and register settings into the steering unit, with
// random gaps and stalls on both streams, while the checker predicts and
// compares every drive beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import lfps_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD      = 60;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 47;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic [S_TDATA_W-1:0]    s_tdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic                    cfg_wr_en;
    logic [CFG_ADDR_W-1:0]   cfg_addr;
    logic [CFG_DATA_W-1:0]   cfg_wdata;

    int mismatch_count;
    int outstanding;
    int drives_checked;

    bit long_hold_req;
    int sink_gap_pct;
    int source_gap_pct;
    int walk_pos;
    int dwell_left;
    int positions_sent;
    int settings_used;

    // Boost window with reset settings, then a lost line and a rejected jump.
    int first_run [9]  = '{16, 16, 16, 16, 16, 16, NO_LINE, 40, 0};
    // Deadband edges, a climb that drives the integral into its low clamp,
    // a jump back that is rejected and a return into the boost window.
    int second_run [16] = '{4, 8, 20, 21, 12, 11, 27, 43, 59, 63, 63, 63, -64, 47, 31, 16};

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    line_follow_pid_steering_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    line_follow_pid_steering_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tdata        (s_tdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .drives_checked (drives_checked)
    );

    task automatic push_position(input int pos);
        if ($urandom_range(1, 100) <= source_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tdata  <= {1'b0, pos[POS_W-1:0]};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        positions_sent++;
    endtask

    // The extra edge lets the checker count the beat accepted at the current edge.
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input int val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        @(posedge aclk);
    endtask

    // Narrow registers get random upper bits that they must ignore.
    task automatic apply_settings(input int sp, input int kp, input int ki, input int kd,
                                  input int cruise, input int boost);
        write_reg(REG_TARGET_POS,   sp | ($urandom_range(0, 63) << 6));
        write_reg(REG_GAIN_P,       kp | ($urandom_range(0, 15) << 8));
        write_reg(REG_GAIN_I,       ki | ($urandom_range(0, 15) << 8));
        write_reg(REG_GAIN_D,       kd | ($urandom_range(0, 15) << 8));
        write_reg(REG_CRUISE_SPEED, cruise);
        write_reg(REG_BOOST_SPEED,  boost);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Mostly a bounded random walk that the filter lets through, with runs inside
    // the boost window, lost lines and arbitrary values mixed in.
    function automatic int next_position();
        int pick;
        if (dwell_left > 0) begin
            dwell_left--;
            return $urandom_range(BOOST_LO + 1, BOOST_HI - 1);
        end
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            return NO_LINE;
        end
        if (pick < 16) begin
            return int'($urandom_range(0, 127)) - 64;
        end
        if (pick < 22) begin
            dwell_left = $urandom_range(3, 20);
            walk_pos   = 16;
            return walk_pos;
        end
        walk_pos += int'($urandom_range(0, 32)) - 16;
        if (walk_pos > 63) begin
            walk_pos = 63;
        end
        if (walk_pos < -64) begin
            walk_pos = -64;
        end
        return walk_pos;
    endfunction

    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if ($urandom_range(1, 100) <= sink_gap_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("No beat moved for %0d cycles.", WATCHDOG_LIMIT);
        $display("line_follow_pid_steering_unit test failed");
        $finish;
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= REG_TARGET_POS;
        cfg_wdata <= '0;
        long_hold_req  = 1'b0;
        sink_gap_pct   = 25;
        source_gap_pct = 25;
        walk_pos       = 0;
        dwell_left     = 0;
        positions_sent = 0;
        settings_used  = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (first_run[i]) push_position(first_run[i]);
        wait_all_results();
        apply_settings(16, 12, 3, 7, 900, 1500);
        foreach (second_run[i]) push_position(second_run[i]);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_all_results();
            if (ph == 0) begin
                apply_settings(63, 255, 255, 255, 4095, 4095);
            end else if (ph == 1) begin
                apply_settings(0, 0, 0, 0, 0, 0);
            end else begin
                apply_settings($urandom_range(0, 63), $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 4095), $urandom_range(0, 4095));
            end
            source_gap_pct = (ph == RANDOM_PHASES - 1) ? 0 : 20 * $urandom_range(0, 2);
            sink_gap_pct   = (ph == RANDOM_PHASES - 1) ? 0 : 20 * $urandom_range(0, 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == 10) begin
                    long_hold_req = 1'b1;
                end
                if (ph == 3 && n == 20) begin
                    wait_all_results();
                end
                push_position(next_position());
            end
        end

        wait_all_results();
        repeat (4) @(posedge aclk);
        $display("Checked %0d drive beats from %0d positions under %0d register settings,",
                 drives_checked, positions_sent, settings_used);
        $display("with lost lines, rejected jumps, integral clamps and boost window runs.");
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("line_follow_pid_steering_unit test passed");
        end else begin
            $display("line_follow_pid_steering_unit test failed");
        end
        $finish;
    end

endmodule

// ===== line_follow_pid_steering_unit.f =====
+incdir+sv
sv/lfps_pkg.sv
sv/lfps_pid_core.sv
sv/line_follow_pid_steering_unit.sv
dv/line_follow_pid_steering_checker.sv
dv/tb.sv
